@@ rtl/rbst_pkg.sv @@
// Shared types, register indexes and the fixed-point scaling function
// for the ray versus box slab test. No dependencies.
`timescale 1ns / 1ps

package rbst_pkg;

    localparam int CoordWidth = 32;
    localparam int DistWidth  = 31;
    localparam int DiffWidth  = CoordWidth + 1;
    localparam int ProdWidth  = DiffWidth + CoordWidth;
    localparam int FracBits   = 16;
    localparam int CfgIdxWidth = 3;

    typedef logic signed [CoordWidth-1:0] coord_t;
    typedef logic [DistWidth-1:0]         dist_t;
    typedef logic signed [DiffWidth-1:0]  diff_t;
    typedef logic signed [ProdWidth-1:0]  prod_t;
    typedef logic [CfgIdxWidth-1:0]       cfg_idx_t;

    localparam cfg_idx_t REG_BOX_MIN_X    = 3'd0;
    localparam cfg_idx_t REG_BOX_MIN_Y    = 3'd1;
    localparam cfg_idx_t REG_BOX_MIN_Z    = 3'd2;
    localparam cfg_idx_t REG_BOX_MAX_X    = 3'd3;
    localparam cfg_idx_t REG_BOX_MAX_Y    = 3'd4;
    localparam cfg_idx_t REG_BOX_MAX_Z    = 3'd5;
    localparam cfg_idx_t REG_MIN_DISTANCE = 3'd6;

    localparam coord_t COORD_MIN = {1'b1, {(CoordWidth-1){1'b0}}};
    localparam coord_t COORD_MAX = {1'b0, {(CoordWidth-1){1'b1}}};
    localparam dist_t  MIN_DISTANCE_RESET = dist_t'(1);

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
        dist_t  min_distance;
    } box_cfg_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_adv_t;

    // Floor shift by the fraction bits, then saturate to the coordinate range
    function automatic coord_t scale_sat(input prod_t p);
        logic [ProdWidth-FracBits-1:0] q;
        logic [ProdWidth-FracBits-CoordWidth:0] top;
        coord_t r;
        q   = p[ProdWidth-1:FracBits];
        top = q[ProdWidth-FracBits-1:CoordWidth-1];
        if ((&top) || !(|top))
        begin
            r = q[CoordWidth-1:0];
        end
        else
        begin
            r = p[ProdWidth-1] ? COORD_MIN : COORD_MAX;
        end
        return r;
    endfunction

endpackage

@@ rtl/rbst_if.sv @@
// Valid/ready channel interfaces for rays in and hit results out.
// Depends on rbst_pkg.
`timescale 1ns / 1ps

interface rbst_ray_if
    import rbst_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t inv_dir_x;
    coord_t inv_dir_y;
    coord_t inv_dir_z;
    logic   neg_dir_x;
    logic   neg_dir_y;
    logic   neg_dir_z;
    dist_t  best_distance;

    modport source (
        output valid, origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
               neg_dir_x, neg_dir_y, neg_dir_z, best_distance,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
               neg_dir_x, neg_dir_y, neg_dir_z, best_distance,
        output ready
    );
endinterface

interface rbst_hit_if
    import rbst_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  is_hit;
    dist_t new_best;

    modport source (
        output valid, is_hit, new_best,
        input  ready
    );
    modport sink (
        input  valid, is_hit, new_best,
        output ready
    );
endinterface

@@ rtl/rbst_cfg_regs.sv @@
// Box corner and minimum distance configuration registers.
// Depends on rbst_pkg.
`timescale 1ns / 1ps

module rbst_cfg_regs
    import rbst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_idx_t              cfg_index,
    input  logic [CoordWidth-1:0] cfg_wdata,
    output box_cfg_t              box
);

    box_cfg_t box_reg;
    box_cfg_t box_next;

    always_comb
    begin
        box_next = box_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BOX_MIN_X:    box_next.min_x = cfg_wdata;
                REG_BOX_MIN_Y:    box_next.min_y = cfg_wdata;
                REG_BOX_MIN_Z:    box_next.min_z = cfg_wdata;
                REG_BOX_MAX_X:    box_next.max_x = cfg_wdata;
                REG_BOX_MAX_Y:    box_next.max_y = cfg_wdata;
                REG_BOX_MAX_Z:    box_next.max_z = cfg_wdata;
                REG_MIN_DISTANCE: box_next.min_distance = cfg_wdata[DistWidth-1:0];
                default:          box_next = box_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.min_x        <= COORD_MIN;
            box_reg.min_y        <= COORD_MIN;
            box_reg.min_z        <= COORD_MIN;
            box_reg.max_x        <= COORD_MAX;
            box_reg.max_y        <= COORD_MAX;
            box_reg.max_z        <= COORD_MAX;
            box_reg.min_distance <= MIN_DISTANCE_RESET;
        end
        else
        begin
            box_reg <= box_next;
        end
    end

    assign box = box_reg;

endmodule

@@ rtl/rbst_slab_axis.sv @@
// One axis of the slab test: difference, product, scale and swap over
// three pipeline stages. Depends on rbst_pkg.
`timescale 1ns / 1ps

module rbst_slab_axis
    import rbst_pkg::*;
(
    input  logic       clk,
    input  stage_adv_t adv,
    input  coord_t     corner_lo,
    input  coord_t     corner_hi,
    input  coord_t     origin,
    input  coord_t     inv_dir,
    input  logic       neg_dir,
    output coord_t     t_entry,
    output coord_t     t_exit
);

    diff_t  d_lo_reg, d_hi_reg, d_lo_next, d_hi_next;
    coord_t inv_s1_reg;
    logic   neg_s1_reg, neg_s2_reg;
    prod_t  p_lo_reg, p_hi_reg, p_lo_next, p_hi_next;
    coord_t t0, t1;
    coord_t entry_reg, exit_reg;

    assign d_lo_next = diff_t'(corner_lo) - diff_t'(origin);
    assign d_hi_next = diff_t'(corner_hi) - diff_t'(origin);

    assign p_lo_next = d_lo_reg * inv_s1_reg;
    assign p_hi_next = d_hi_reg * inv_s1_reg;

    assign t0 = scale_sat(p_lo_reg);
    assign t1 = scale_sat(p_hi_reg);

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            d_lo_reg   <= d_lo_next;
            d_hi_reg   <= d_hi_next;
            inv_s1_reg <= inv_dir;
            neg_s1_reg <= neg_dir;
        end
        if (adv.s2)
        begin
            p_lo_reg   <= p_lo_next;
            p_hi_reg   <= p_hi_next;
            neg_s2_reg <= neg_s1_reg;
        end
        if (adv.s3)
        begin
            entry_reg <= neg_s2_reg ? t1 : t0;
            exit_reg  <= neg_s2_reg ? t0 : t1;
        end
    end

    assign t_entry = entry_reg;
    assign t_exit  = exit_reg;

endmodule

@@ rtl/ray_box_slab_test_top.sv @@
// Top level of the ray versus axis-aligned box slab test.
// Depends on rbst_pkg, rbst_if, rbst_cfg_regs and rbst_slab_axis.
`timescale 1ns / 1ps

// One ray is accepted every clock cycle unless an output stall reaches the
// input. The five register stages are: corner minus origin, the 33 x 32 bit
// products, scale and saturate with the slab swap, a first max/min pair, and
// the final reduction with the hit decision in the output register. Each
// stage advances when it is empty or the stage after it moves, so a stalled
// output holds results in place while earlier empty stages keep filling.
// Configuration writes take effect at once and are meant for an idle block.
module ray_box_slab_test_top
    import rbst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_idx_t              cfg_index,
    input  logic [CoordWidth-1:0] cfg_wdata,
    rbst_ray_if.sink              ray,
    rbst_hit_if.source            hit
);

    box_cfg_t   box;
    stage_adv_t adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    dist_t best_s1_reg, best_s2_reg, best_s3_reg, best_s4_reg;

    coord_t ex, ey, ez, xx, xy, xz;
    coord_t min_dist_s;
    coord_t tmin_a_reg, tmin_b_reg, tmax_a_reg, tmax_b_reg;
    coord_t tmin, tmax;
    logic   hit_next;
    logic   is_hit_reg;
    dist_t  new_best_reg;

    rbst_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .box       (box)
    );

    assign adv.s5 = !v5_reg || hit.ready;
    assign adv.s4 = !v4_reg || adv.s5;
    assign adv.s3 = !v3_reg || adv.s4;
    assign adv.s2 = !v2_reg || adv.s3;
    assign adv.s1 = !v1_reg || adv.s2;

    assign ray.ready = adv.s1;

    rbst_slab_axis u_axis_x (
        .clk       (clk),
        .adv       (adv),
        .corner_lo (box.min_x),
        .corner_hi (box.max_x),
        .origin    (ray.origin_x),
        .inv_dir   (ray.inv_dir_x),
        .neg_dir   (ray.neg_dir_x),
        .t_entry   (ex),
        .t_exit    (xx)
    );

    rbst_slab_axis u_axis_y (
        .clk       (clk),
        .adv       (adv),
        .corner_lo (box.min_y),
        .corner_hi (box.max_y),
        .origin    (ray.origin_y),
        .inv_dir   (ray.inv_dir_y),
        .neg_dir   (ray.neg_dir_y),
        .t_entry   (ey),
        .t_exit    (xy)
    );

    rbst_slab_axis u_axis_z (
        .clk       (clk),
        .adv       (adv),
        .corner_lo (box.min_z),
        .corner_hi (box.max_z),
        .origin    (ray.origin_z),
        .inv_dir   (ray.inv_dir_z),
        .neg_dir   (ray.neg_dir_z),
        .t_entry   (ez),
        .t_exit    (xz)
    );

    assign min_dist_s = coord_t'({1'b0, box.min_distance});

    assign tmin = (tmin_a_reg > tmin_b_reg) ? tmin_a_reg : tmin_b_reg;
    assign tmax = (tmax_a_reg < tmax_b_reg) ? tmax_a_reg : tmax_b_reg;
    assign hit_next = (tmax > tmin) && (tmin < coord_t'({1'b0, best_s4_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv.s1)
            begin
                v1_reg <= ray.valid;
            end
            if (adv.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv.s4)
            begin
                v4_reg <= v3_reg;
            end
            if (adv.s5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            best_s1_reg <= ray.best_distance;
        end
        if (adv.s2)
        begin
            best_s2_reg <= best_s1_reg;
        end
        if (adv.s3)
        begin
            best_s3_reg <= best_s2_reg;
        end
        if (adv.s4)
        begin
            best_s4_reg <= best_s3_reg;
            tmin_a_reg  <= (ex > min_dist_s) ? ex : min_dist_s;
            tmin_b_reg  <= (ey > ez) ? ey : ez;
            tmax_a_reg  <= (xx < COORD_MAX) ? xx : COORD_MAX;
            tmax_b_reg  <= (xy < xz) ? xy : xz;
        end
        if (adv.s5)
        begin
            is_hit_reg   <= hit_next;
            new_best_reg <= hit_next ? tmin[DistWidth-1:0] : best_s4_reg;
        end
    end

    assign hit.valid    = v5_reg;
    assign hit.is_hit   = is_hit_reg;
    assign hit.new_best = new_best_reg;

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the ray versus box slab test: valid/ready driver and monitor,
// a fixed-point predictor of the hit decision and an in-order result check.
// Depends on rbst_pkg, rbst_if and ray_box_slab_test_top.
`timescale 1ns / 1ps

module tb;
    import rbst_pkg::*;

    localparam int ONE      = 65536;
    localparam int HOLD_AT  = 100;
    localparam int HOLD_LEN = 80;
    localparam dist_t BEST_MAX = '1;

    typedef struct packed {
        logic [2:0][CoordWidth-1:0] origin;
        logic [2:0][CoordWidth-1:0] inv_dir;
        logic [2:0]                 neg_dir;
        dist_t                      best;
    } ray_t;

    typedef struct packed {
        logic  is_hit;
        dist_t new_best;
    } hit_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_we = 1'b0;
    cfg_idx_t cfg_index = REG_BOX_MIN_X;
    logic [CoordWidth-1:0] cfg_wdata = '0;

    logic ray_valid = 1'b0;
    ray_t ray_q = '0;
    logic hit_ready = 1'b0;

    ray_t pending_rays[$];
    hit_t expected_hits[$];
    hit_t oldest_hit;

    coord_t box_lo[3];
    coord_t box_hi[3];
    dist_t  near_limit;

    bit src_gaps_on = 1'b1;
    bit sink_gaps_on = 1'b1;
    bit src_pause = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int rays_sent = 0;
    int results_seen = 0;
    int errors = 0;

    rbst_ray_if ray_ch ();
    rbst_hit_if hit_ch ();

    assign ray_ch.valid         = ray_valid;
    assign ray_ch.origin_x      = ray_q.origin[0];
    assign ray_ch.origin_y      = ray_q.origin[1];
    assign ray_ch.origin_z      = ray_q.origin[2];
    assign ray_ch.inv_dir_x     = ray_q.inv_dir[0];
    assign ray_ch.inv_dir_y     = ray_q.inv_dir[1];
    assign ray_ch.inv_dir_z     = ray_q.inv_dir[2];
    assign ray_ch.neg_dir_x     = ray_q.neg_dir[0];
    assign ray_ch.neg_dir_y     = ray_q.neg_dir[1];
    assign ray_ch.neg_dir_z     = ray_q.neg_dir[2];
    assign ray_ch.best_distance = ray_q.best;
    assign hit_ch.ready         = hit_ready;

    ray_box_slab_test_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ray       (ray_ch.sink),
        .hit       (hit_ch.source)
    );

    function automatic coord_t slab_distance(input coord_t corner, input coord_t origin,
                                             input coord_t inv);
        logic signed [DiffWidth-1:0] gap;
        logic signed [ProdWidth-1:0] prod;
        logic signed [ProdWidth-FracBits-1:0] scaled;
        gap    = corner - origin;
        prod   = gap * inv;
        scaled = prod >>> FracBits;
        if (scaled > 49'sd2147483647)
        begin
            return COORD_MAX;
        end
        if (scaled < -49'sd2147483648)
        begin
            return COORD_MIN;
        end
        return scaled[CoordWidth-1:0];
    endfunction

    function automatic hit_t predict_hit(input ray_t r);
        logic signed [DiffWidth-1:0] entry_t;
        logic signed [DiffWidth-1:0] exit_t;
        logic signed [DiffWidth-1:0] t_near;
        logic signed [DiffWidth-1:0] t_far;
        logic signed [DiffWidth-1:0] t_swap;
        hit_t res;
        entry_t = $signed({2'b00, near_limit});
        exit_t  = COORD_MAX;
        for (int i = 0; i < 3; i++)
        begin
            t_near = slab_distance(box_lo[i], r.origin[i], r.inv_dir[i]);
            t_far  = slab_distance(box_hi[i], r.origin[i], r.inv_dir[i]);
            if (r.neg_dir[i])
            begin
                t_swap = t_near;
                t_near = t_far;
                t_far  = t_swap;
            end
            if (t_near > entry_t)
            begin
                entry_t = t_near;
            end
            if (t_far < exit_t)
            begin
                exit_t = t_far;
            end
        end
        if (exit_t > entry_t && entry_t < $signed({2'b00, r.best}))
        begin
            res.is_hit   = 1'b1;
            res.new_best = entry_t[DistWidth-1:0];
        end
        else
        begin
            res.is_hit   = 1'b0;
            res.new_best = r.best;
        end
        return res;
    endfunction

    function automatic ray_t mk_ray(input coord_t ox, input coord_t oy, input coord_t oz,
                                    input coord_t ix, input coord_t iy, input coord_t iz,
                                    input logic [2:0] neg, input dist_t best);
        ray_t r;
        r.origin  = {oz, oy, ox};
        r.inv_dir = {iz, iy, ix};
        r.neg_dir = neg;
        r.best    = best;
        return r;
    endfunction

    function automatic ray_t random_ray(input bit force_noise);
        ray_t r;
        logic [CoordWidth-1:0] mag;
        r = '0;
        if (force_noise || $urandom_range(0, 3) == 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r.origin[i]  = $urandom;
                r.inv_dir[i] = $urandom;
            end
            r.neg_dir = 3'($urandom);
            r.best    = dist_t'($urandom);
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                r.origin[i] = $urandom_range(0, 16 * ONE) - 8 * ONE;
                case ($urandom_range(0, 9))
                    0:
                    begin
                        r.inv_dir[i] = COORD_MAX;
                        r.neg_dir[i] = 1'b0;
                    end
                    1:
                    begin
                        r.inv_dir[i] = COORD_MIN;
                        r.neg_dir[i] = 1'b1;
                    end
                    default:
                    begin
                        mag          = $urandom_range(ONE / 16, 16 * ONE);
                        r.neg_dir[i] = 1'($urandom_range(0, 1));
                        r.inv_dir[i] = r.neg_dir[i] ? -mag : mag;
                    end
                endcase
            end
            r.best = ($urandom_range(0, 3) == 0) ? BEST_MAX
                                                  : dist_t'($urandom_range(0, 24 * ONE));
        end
        return r;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CoordWidth-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_BOX_MIN_X:    box_lo[0] = value;
            REG_BOX_MIN_Y:    box_lo[1] = value;
            REG_BOX_MIN_Z:    box_lo[2] = value;
            REG_BOX_MAX_X:    box_hi[0] = value;
            REG_BOX_MAX_Y:    box_hi[1] = value;
            REG_BOX_MAX_Z:    box_hi[2] = value;
            REG_MIN_DISTANCE: near_limit = value[DistWidth-1:0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_box(input logic [2:0][CoordWidth-1:0] lo,
                           input logic [2:0][CoordWidth-1:0] hi, input dist_t md);
        for (int i = 0; i < 3; i++)
        begin
            write_reg(cfg_idx_t'(REG_BOX_MIN_X + i), lo[i]);
            write_reg(cfg_idx_t'(REG_BOX_MAX_X + i), hi[i]);
        end
        write_reg(REG_MIN_DISTANCE, {1'b0, md});
        cfg_we <= 1'b0;
    endtask

    // sample on the falling edge so the driver and monitor have settled
    task automatic wait_idle();
        while (pending_rays.size() != 0 || ray_valid || expected_hits.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic push_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            pending_rays.push_back(random_ray(1'b0));
        end
    endtask

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #400000;
        $display("[ray_box_slab_test_top] ERROR");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_valid <= 1'b0;
        end
        else
        begin
            if (ray_valid && ray_ch.ready)
            begin
                expected_hits.push_back(predict_hit(ray_q));
                rays_sent++;
            end
            if (!ray_valid || ray_ch.ready)
            begin
                if (pending_rays.size() != 0 && !src_pause &&
                    !(src_gaps_on && $urandom_range(0, 99) < 6))
                begin
                    ray_q     <= pending_rays.pop_front();
                    ray_valid <= 1'b1;
                end
                else
                begin
                    ray_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_ready <= 1'b0;
        end
        else
        begin
            if (hit_ch.valid && hit_ready)
            begin
                results_seen++;
                if (expected_hits.size() == 0)
                begin
                    $display("%0t unexpected transaction: is_hit=%0b new_best=%0d",
                             $time, hit_ch.is_hit, hit_ch.new_best);
                    errors++;
                end
                else
                begin
                    oldest_hit = expected_hits.pop_front();
                    if (hit_ch.is_hit !== oldest_hit.is_hit)
                    begin
                        $display("%0t is_hit mismatch: expected %0b actual %0b",
                                 $time, oldest_hit.is_hit, hit_ch.is_hit);
                        errors++;
                    end
                    if (hit_ch.new_best !== oldest_hit.new_best)
                    begin
                        $display("%0t new_best mismatch: expected %0d actual %0d",
                                 $time, oldest_hit.new_best, hit_ch.new_best);
                        errors++;
                    end
                end
            end
            // hold off long enough to back the pipeline up into the ray input
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                hit_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_left <= HOLD_LEN;
                hold_done <= 1'b1;
                hit_ready <= 1'b0;
            end
            else
            begin
                hit_ready <= !(sink_gaps_on && $urandom_range(0, 99) < 6);
            end
        end
    end

    initial
    begin
        logic [2:0][CoordWidth-1:0] lo;
        logic [2:0][CoordWidth-1:0] hi;
        int base;
        for (int i = 0; i < 3; i++)
        begin
            box_lo[i] = COORD_MIN;
            box_hi[i] = COORD_MAX;
        end
        near_limit = MIN_DISTANCE_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset box spans the whole range
        pending_rays.push_back(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX,
                                      3'b000, BEST_MAX));
        pending_rays.push_back(mk_ray(COORD_MIN, COORD_MIN, COORD_MIN,
                                      COORD_MAX, COORD_MAX, COORD_MAX, 3'b000, BEST_MAX));
        pending_rays.push_back(random_ray(1'b1));
        pending_rays.push_back(random_ray(1'b1));
        wait_idle();

        set_box({-2 * ONE, -2 * ONE, -2 * ONE}, {2 * ONE, 2 * ONE, 2 * ONE}, dist_t'(1));
        pending_rays.push_back(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX,
                                      3'b000, BEST_MAX));
        pending_rays.push_back(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX,
                                      3'b000, dist_t'(3 * ONE)));
        pending_rays.push_back(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX,
                                      3'b000, dist_t'(3 * ONE + 1)));
        pending_rays.push_back(mk_ray(5 * ONE, 0, 0, -ONE, COORD_MAX, COORD_MAX,
                                      3'b001, BEST_MAX));
        pending_rays.push_back(mk_ray(5 * ONE, 0, 0, -ONE, COORD_MAX, COORD_MAX,
                                      3'b000, BEST_MAX));
        pending_rays.push_back(mk_ray(-5 * ONE, -9 * ONE, 0, ONE, ONE, COORD_MAX,
                                      3'b000, BEST_MAX));
        pending_rays.push_back(mk_ray(0, 0, 0, ONE, ONE, ONE, 3'b000, BEST_MAX));
        pending_rays.push_back(mk_ray(5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX,
                                      3'b000, BEST_MAX));
        pending_rays.push_back(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX,
                                      3'b000, '0));
        pending_rays.push_back(mk_ray(COORD_MIN, COORD_MIN, COORD_MIN,
                                      COORD_MAX, COORD_MAX, COORD_MAX, 3'b000, BEST_MAX));
        pending_rays.push_back(mk_ray(COORD_MAX, COORD_MAX, COORD_MAX,
                                      COORD_MIN, COORD_MIN, COORD_MIN, 3'b111, BEST_MAX));
        pending_rays.push_back(mk_ray(0, 0, 0, 0, 0, 0, 3'b000, BEST_MAX));
        pending_rays.push_back(mk_ray(5 * ONE, 0, 0, COORD_MIN, COORD_MAX, COORD_MAX,
                                      3'b001, BEST_MAX));
        pending_rays.push_back(mk_ray(-5 * ONE, -5 * ONE, -5 * ONE, ONE, ONE, ONE,
                                      3'b000, BEST_MAX));
        pending_rays.push_back(mk_ray(5 * ONE, 5 * ONE, 5 * ONE, -ONE, -ONE, -ONE,
                                      3'b111, dist_t'(4 * ONE)));
        pending_rays.push_back(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MIN, COORD_MAX,
                                      3'b010, BEST_MAX));
        for (int n = 0; n < 3; n++)
        begin
            pending_rays.push_back(random_ray(1'b1));
        end
        push_random(320);
        wait_idle();

        // inverted box at the corners of the range, largest entry bound
        set_box({COORD_MAX, COORD_MAX, COORD_MAX}, {COORD_MIN, COORD_MIN, COORD_MIN},
                BEST_MAX);
        pending_rays.push_back(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX,
                                      3'b000, BEST_MAX));
        pending_rays.push_back(mk_ray(0, 0, 0, ONE, ONE, ONE, 3'b000, BEST_MAX));
        pending_rays.push_back(mk_ray(COORD_MAX, COORD_MAX, COORD_MAX,
                                      COORD_MIN, COORD_MIN, COORD_MIN, 3'b111, BEST_MAX));
        push_random(40);
        wait_idle();

        set_box({-2 * ONE, -2 * ONE, -2 * ONE}, {2 * ONE, 2 * ONE, 2 * ONE}, '0);
        pending_rays.push_back(mk_ray(0, 0, 0, ONE, ONE, ONE, 3'b000, BEST_MAX));
        pending_rays.push_back(mk_ray(-5 * ONE, 0, 0, ONE, COORD_MAX, COORD_MAX,
                                      3'b000, BEST_MAX));
        wait_idle();

        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo[i] = $urandom_range(0, 8 * ONE) - 4 * ONE;
                hi[i] = lo[i] + $urandom_range(0, 4 * ONE);
            end
            set_box(lo, hi, dist_t'($urandom_range(0, ONE / 8)));
            src_gaps_on  = (k != 1);
            sink_gaps_on = (k != 1);
            base = rays_sent;
            push_random(70);
            if (k == 2)
            begin
                while (rays_sent < base + 35)
                begin
                    @(negedge clk);
                end
                src_pause = 1'b1;
                @(negedge clk);
                while (ray_valid || expected_hits.size() != 0)
                begin
                    @(negedge clk);
                end
                src_pause = 1'b0;
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("[ray_box_slab_test_top] OK");
        end
        else
        begin
            $display("[ray_box_slab_test_top] ERROR");
        end
        $finish;
    end

endmodule

@@ ray_box_slab_test_top.f @@
rtl/rbst_pkg.sv
rtl/rbst_if.sv
rtl/rbst_cfg_regs.sv
rtl/rbst_slab_axis.sv
rtl/ray_box_slab_test_top.sv
tb/sv/tb.sv
